// ===== rtl/core/asc_pkg.sv =====
// Shared types and constants for the annular sector classifier.
// The configuration register codes, the arctangent table and the cell control struct live here.
// No dependencies.
package asc_pkg;

    localparam int ANGLE_W     = 17;
    localparam int RADIUS_W    = 15;
    localparam int RADIUS_SQ_W = 2 * RADIUS_W;
    localparam int Z_W         = 18;
    localparam int GUARD_SHIFT = 16;
    localparam int TABLE_LEN   = 24;
    localparam int ATAN_W      = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_HIGH = 3'd4;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LOW_RST  = -17'sd32768;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HIGH_RST = 17'sd32768;
    localparam logic [RADIUS_SQ_W-1:0]    RADIUS_LOW_SQ_RST  = 30'd0;
    localparam logic [RADIUS_SQ_W-1:0]    RADIUS_HIGH_SQ_RST = 30'd1073676289;

    // Half a turn in angle units, used for the left half plane start and for clamping.
    localparam logic signed [Z_W-1:0] Z_HALF_TURN = 18'sd32768;
    localparam logic signed [Z_W-1:0] Z_NEG_HALF_TURN = -18'sd32768;

    // round(atan(2^-i) * 32768 / pi)
    localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0,
        14'd0,    14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0,   14'd0
    };

    typedef struct packed {
        logic valid;
        logic keep;
    } t_cell_ctl;

endpackage

// ===== rtl/core/asc_cordic_cell.sv =====
// One vectoring stage of the arctangent chain, with its pipeline register.
// Depends on asc_pkg for the arctangent table and the control struct.
module asc_cordic_cell #(
    parameter int XY_W  = 35,
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  asc_pkg::t_cell_ctl            i_ctl,
    input  logic signed [XY_W-1:0]        i_x,
    input  logic signed [XY_W-1:0]        i_y,
    input  logic signed [asc_pkg::Z_W-1:0] i_z,
    output asc_pkg::t_cell_ctl            o_ctl,
    output logic signed [XY_W-1:0]        o_x,
    output logic signed [XY_W-1:0]        o_y,
    output logic signed [asc_pkg::Z_W-1:0] o_z
);
    import asc_pkg::*;

    localparam logic signed [Z_W-1:0] STEP =
        signed'({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[STAGE]});

    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic signed [XY_W-1:0] n_x;
    logic signed [XY_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;
    t_cell_ctl              r_ctl;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    // Rotate toward the positive x axis; the sign of y picks the direction.
    always_comb begin
        if (!i_y[XY_W-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + STEP;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== rtl/core/annular_sector_classifier.sv =====
// Top level of the annular sector classifier: stick select, radius test, CORDIC cell chain
// and the sector decision. Depends on asc_pkg and asc_cordic_cell.
//
//   channel   direction  handshake                        payload
//   request   in         i_start, o_busy                  i_left_x, i_left_y, i_right_x, i_right_y
//   result    out        o_done (one-cycle strobe)        o_in_sector
//   config    in         i_cfg_valid, o_cfg_ready         i_cfg_index, i_cfg_data
//
// One request is taken every clock cycle while o_busy is low. Its result strobes on o_done after
// passing a select register, an init/square register, one register per CORDIC cell (stage count
// capped at 24), and the output register.
// o_busy is high during reset and for one cycle after it; otherwise it stays low.
// The receiver cannot stall, so results leave on o_done without any backpressure.
module annular_sector_classifier #(
    parameter int CORDIC_STAGES = 16,
    parameter int AXIS_WIDTH    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [AXIS_WIDTH-1:0]     i_left_x,
    input  logic signed [AXIS_WIDTH-1:0]     i_left_y,
    input  logic signed [AXIS_WIDTH-1:0]     i_right_x,
    input  logic signed [AXIS_WIDTH-1:0]     i_right_y,
    output logic                             o_done,
    output logic                             o_in_sector,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import asc_pkg::*;

    localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int XY_W  = AXIS_WIDTH + GUARD_SHIFT + 3;
    localparam int SQ_W  = 2 * AXIS_WIDTH;
    localparam int CMP_W = (SQ_W > RADIUS_SQ_W) ? SQ_W : RADIUS_SQ_W;
    localparam int PAD_W = XY_W - AXIS_WIDTH - GUARD_SHIFT;

    // Configuration registers; radii are kept as squares.
    logic                          r_use_left;
    logic signed [ANGLE_W-1:0]     r_angle_low;
    logic signed [ANGLE_W-1:0]     r_angle_high;
    logic [RADIUS_SQ_W-1:0]        r_lo2;
    logic [RADIUS_SQ_W-1:0]        r_hi2;
    logic [RADIUS_SQ_W-1:0]        w_cfg_sq;
    logic                          r_rst_hold;
    logic                          w_accept;

    assign o_cfg_ready = i_rst_n;
    assign o_busy      = r_rst_hold | ~i_rst_n;
    assign w_accept    = i_start & ~o_busy;
    assign w_cfg_sq    = RADIUS_SQ_W'(i_cfg_data[RADIUS_W-1:0])
                       * RADIUS_SQ_W'(i_cfg_data[RADIUS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_hold   <= 1'b1;
            r_use_left   <= 1'b0;
            r_angle_low  <= ANGLE_LOW_RST;
            r_angle_high <= ANGLE_HIGH_RST;
            r_lo2        <= RADIUS_LOW_SQ_RST;
            r_hi2        <= RADIUS_HIGH_SQ_RST;
        end else begin
            r_rst_hold <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_USE_LEFT:    r_use_left   <= i_cfg_data[0];
                    CFG_ANGLE_LOW:   r_angle_low  <= signed'(i_cfg_data);
                    CFG_ANGLE_HIGH:  r_angle_high <= signed'(i_cfg_data);
                    CFG_RADIUS_LOW:  r_lo2        <= w_cfg_sq;
                    CFG_RADIUS_HIGH: r_hi2        <= w_cfg_sq;
                    default: ;
                endcase
            end
        end
    end

    // Stage 0: pick the stick.
    logic                          r_s0_valid;
    logic signed [AXIS_WIDTH-1:0]  r_s0_x;
    logic signed [AXIS_WIDTH-1:0]  r_s0_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_x <= r_use_left ? i_left_x : i_right_x;
        r_s0_y <= r_use_left ? i_left_y : i_right_y;
    end

    // Stage 1: squares for the radius test and the CORDIC starting vector.
    logic signed [XY_W-1:0]  w_xw;
    logic signed [XY_W-1:0]  w_yw;
    logic signed [XY_W-1:0]  n_s1_x;
    logic signed [XY_W-1:0]  n_s1_y;
    logic signed [Z_W-1:0]   n_s1_z;
    logic signed [SQ_W-1:0]  w_px;
    logic signed [SQ_W-1:0]  w_py;
    logic                    r_s1_valid;
    logic                    r_s1_nz;
    logic signed [XY_W-1:0]  r_s1_x;
    logic signed [XY_W-1:0]  r_s1_y;
    logic signed [Z_W-1:0]   r_s1_z;
    logic [SQ_W-2:0]         r_sqx;
    logic [SQ_W-2:0]         r_sqy;

    assign w_xw = {{PAD_W{r_s0_x[AXIS_WIDTH-1]}}, r_s0_x, {GUARD_SHIFT{1'b0}}};
    assign w_yw = {{PAD_W{r_s0_y[AXIS_WIDTH-1]}}, r_s0_y, {GUARD_SHIFT{1'b0}}};
    assign w_px = SQ_W'(r_s0_x) * SQ_W'(r_s0_x);
    assign w_py = SQ_W'(r_s0_y) * SQ_W'(r_s0_y);

    // A vector in the left half plane is turned by half a turn first.
    always_comb begin
        if (r_s0_x[AXIS_WIDTH-1]) begin
            n_s1_x = -w_xw;
            n_s1_y = -w_yw;
            n_s1_z = r_s0_y[AXIS_WIDTH-1] ? Z_NEG_HALF_TURN : Z_HALF_TURN;
        end else begin
            n_s1_x = w_xw;
            n_s1_y = w_yw;
            n_s1_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_nz <= (r_s0_x != '0) || (r_s0_y != '0);
        r_s1_x  <= n_s1_x;
        r_s1_y  <= n_s1_y;
        r_s1_z  <= n_s1_z;
        r_sqx   <= w_px[SQ_W-2:0];
        r_sqy   <= w_py[SQ_W-2:0];
    end

    // Radius test rides into the first cell as its keep flag.
    logic [CMP_W-1:0] w_r2;
    logic [CMP_W-1:0] w_lo2;
    logic [CMP_W-1:0] w_hi2;
    logic             w_rad_ok;

    assign w_r2     = CMP_W'({1'b0, r_sqx} + {1'b0, r_sqy});
    assign w_lo2    = CMP_W'(r_lo2);
    assign w_hi2    = CMP_W'(r_hi2);
    assign w_rad_ok = r_s1_nz && (w_r2 >= w_lo2) && (w_r2 < w_hi2);

    t_cell_ctl              w_ctl [NCELL+1];
    logic signed [XY_W-1:0] w_x   [NCELL+1];
    logic signed [XY_W-1:0] w_y   [NCELL+1];
    logic signed [Z_W-1:0]  w_z   [NCELL+1];

    assign w_ctl[0].valid = r_s1_valid;
    assign w_ctl[0].keep  = w_rad_ok;
    assign w_x[0]         = r_s1_x;
    assign w_y[0]         = r_s1_y;
    assign w_z[0]         = r_s1_z;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        asc_cordic_cell #(
            .XY_W  (XY_W),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    // Clamp the angle and apply the sector test.
    logic signed [Z_W-1:0] w_ang;
    logic signed [Z_W-1:0] w_alo;
    logic signed [Z_W-1:0] w_ahi;
    logic                  w_ang_ok;
    logic                  r_done;
    logic                  r_in_sector;

    always_comb begin
        if (w_z[NCELL] > Z_HALF_TURN) begin
            w_ang = Z_HALF_TURN;
        end else if (w_z[NCELL] < Z_NEG_HALF_TURN) begin
            w_ang = Z_NEG_HALF_TURN;
        end else begin
            w_ang = w_z[NCELL];
        end
    end

    assign w_alo = Z_W'(r_angle_low);
    assign w_ahi = Z_W'(r_angle_high);

    // When the end lies below the start, the sector wraps through the negative x axis.
    assign w_ang_ok = (w_ahi < w_alo) ? ((w_ang >= w_alo) || (w_ang < w_ahi))
                                      : ((w_ang >= w_alo) && (w_ang < w_ahi));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_in_sector <= 1'b0;
        end else begin
            r_done      <= w_ctl[NCELL].valid;
            r_in_sector <= w_ctl[NCELL].valid & w_ctl[NCELL].keep & w_ang_ok;
        end
    end

    assign o_done      = r_done;
    assign o_in_sector = r_in_sector;

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(NCELL+3) o_done)
        else $error("accepted request did not produce a result on time");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, NCELL+3))
        else $error("result strobe without a matching request");

    a_center_false: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_nz) |-> ##(NCELL+1) (o_done && !o_in_sector))
        else $error("stick at the center reported inside the sector");

endmodule

// ===== test/asc_sector_checker.sv =====
// Request/result checker for the annular sector classifier: watches the request, result and
// register channels, predicts each in_sector decision and compares in order.
// Depends on asc_pkg for the register index codes.
module asc_sector_checker #(
    parameter int STAGES = 16,
    parameter int AXIS_W = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic signed [AXIS_W-1:0]        i_left_x,
    input  logic signed [AXIS_W-1:0]        i_left_y,
    input  logic signed [AXIS_W-1:0]        i_right_x,
    input  logic signed [AXIS_W-1:0]        i_right_y,
    input  logic                            i_done,
    input  logic                            i_in_sector,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_errors,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_hits
);
    import asc_pkg::*;

    localparam int HEADING_STEPS = 24;
    localparam int GUARD = 16;
    localparam longint HALF_TURN = 32768;

    // Rotation per vectoring step, round(atan(2^-i) * 32768 / pi).
    localparam int ARCTAN_STEP [0:HEADING_STEPS-1] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic   in_sector;
        longint x;
        longint y;
    } t_sector_call;

    t_sector_call sector_calls_q[$];

    logic                      use_left;
    logic signed [ANGLE_W-1:0] angle_lo;
    logic signed [ANGLE_W-1:0] angle_hi;
    logic [RADIUS_W-1:0]       radius_lo;
    logic [RADIUS_W-1:0]       radius_hi;

    function automatic longint cordic_heading(input longint px, input longint py);
        longint cx, cy, cz, sx, sy;
        int     i;
        cx = px * (64'sd1 <<< GUARD);
        cy = py * (64'sd1 <<< GUARD);
        cz = 0;
        if (cx < 0) begin
            cz = (cy >= 0) ? HALF_TURN : -HALF_TURN;
            cx = -cx;
            cy = -cy;
        end
        for (i = 0; i < STAGES && i < HEADING_STEPS; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0) begin
                cx = cx + sy;
                cy = cy - sx;
                cz = cz + ARCTAN_STEP[i];
            end else begin
                cx = cx - sy;
                cy = cy + sx;
                cz = cz - ARCTAN_STEP[i];
            end
        end
        if (cz > HALF_TURN) cz = HALF_TURN;
        if (cz < -HALF_TURN) cz = -HALF_TURN;
        return cz;
    endfunction

    function automatic logic sector_contains(input longint px, input longint py);
        longint dist_sq, lo_sq, hi_sq, heading;
        logic   ang_ok, rad_ok;
        if (px == 0 && py == 0) return 1'b0;
        dist_sq = px * px + py * py;
        lo_sq   = longint'(radius_lo) * longint'(radius_lo);
        hi_sq   = longint'(radius_hi) * longint'(radius_hi);
        rad_ok  = (dist_sq >= lo_sq) && (dist_sq < hi_sq);
        heading = cordic_heading(px, py);
        // A sector whose end lies below its start wraps through the negative x axis.
        if (angle_hi < angle_lo) begin
            ang_ok = (heading >= angle_lo) || (heading < angle_hi);
        end else begin
            ang_ok = (heading >= angle_lo) && (heading < angle_hi);
        end
        return ang_ok && rad_ok;
    endfunction

    always @(posedge i_clk) begin
        t_sector_call call;
        t_sector_call got;
        if (!i_rst_n) begin
            use_left      = 1'b0;
            angle_lo      = ANGLE_LOW_RST;
            angle_hi      = ANGLE_HIGH_RST;
            radius_lo     = '0;
            radius_hi     = '1;
            o_errors      = 0;
            o_checked     = 0;
            o_hits        = 0;
            sector_calls_q.delete();
        end else begin
            if (i_done) begin
                if (sector_calls_q.size() == 0) begin
                    $error("in_sector: result with no request outstanding, actual %0b",
                           i_in_sector);
                    o_errors++;
                end else begin
                    got = sector_calls_q.pop_front();
                    o_checked++;
                    if (i_in_sector === 1'b1) o_hits++;
                    if (i_in_sector !== got.in_sector) begin
                        $error("in_sector mismatch at (%0d, %0d): expected %0b, actual %0b",
                               got.x, got.y, got.in_sector, i_in_sector);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                call.x = use_left ? longint'(i_left_x) : longint'(i_right_x);
                call.y = use_left ? longint'(i_left_y) : longint'(i_right_y);
                call.in_sector = sector_contains(call.x, call.y);
                sector_calls_q.push_back(call);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_USE_LEFT:    use_left  = i_cfg_data[0];
                    CFG_ANGLE_LOW:   angle_lo  = i_cfg_data[ANGLE_W-1:0];
                    CFG_ANGLE_HIGH:  angle_hi  = i_cfg_data[ANGLE_W-1:0];
                    CFG_RADIUS_LOW:  radius_lo = i_cfg_data[RADIUS_W-1:0];
                    CFG_RADIUS_HIGH: radius_hi = i_cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = sector_calls_q.size();
    end

endmodule

// ===== test/tb_annular_sector_classifier.sv =====
// Testbench top for the annular sector classifier: clock, reset, register programming and
// stick position requests, directed then random. Depends on asc_pkg, the block and
// asc_sector_checker, which does all prediction and comparison.
module tb_annular_sector_classifier;
    import asc_pkg::*;

    localparam int STAGES  = 16;
    localparam int AXIS_W  = 16;
    localparam int LATENCY = ((STAGES < TABLE_LEN) ? STAGES : TABLE_LEN) + 3;
    localparam int PHASES  = 10;
    localparam int PHASE_REQUESTS = 115;
    localparam longint CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
    localparam real PI = 3.14159265358979;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic signed [AXIS_W-1:0] i_left_x, i_left_y, i_right_x, i_right_y;
    logic o_done;
    logic o_in_sector;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors, outstanding, checked, hits;
    int requests_sent;
    int settings_used;
    longint cycles;

    // Stimulus-side copy of the registers, only used to aim points at the sector edges.
    int cur_use_left;
    int cur_angle_lo, cur_angle_hi;
    int cur_radius_lo, cur_radius_hi;

    annular_sector_classifier #(
        .CORDIC_STAGES(STAGES),
        .AXIS_WIDTH   (AXIS_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_left_x    (i_left_x),
        .i_left_y    (i_left_y),
        .i_right_x   (i_right_x),
        .i_right_y   (i_right_y),
        .o_done      (o_done),
        .o_in_sector (o_in_sector),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    asc_sector_checker #(
        .STAGES(STAGES),
        .AXIS_W(AXIS_W)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_left_x      (i_left_x),
        .i_left_y      (i_left_y),
        .i_right_x     (i_right_x),
        .i_right_y     (i_right_y),
        .i_done        (o_done),
        .i_in_sector   (o_in_sector),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_hits        (hits)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                     outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [AXIS_W-1:0] lx, ly, rx, ry);
        @(negedge i_clk);
        i_start   = 1'b1;
        i_left_x  = lx;
        i_left_y  = ly;
        i_right_x = rx;
        i_right_y = ry;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Holds off until every request has its result, then lets the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_start     = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        case (idx)
            CFG_USE_LEFT:    cur_use_left  = data[0];
            CFG_ANGLE_LOW:   cur_angle_lo  = $signed(data[ANGLE_W-1:0]);
            CFG_ANGLE_HIGH:  cur_angle_hi  = $signed(data[ANGLE_W-1:0]);
            CFG_RADIUS_LOW:  cur_radius_lo = data[RADIUS_W-1:0];
            CFG_RADIUS_HIGH: cur_radius_hi = data[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [AXIS_W-1:0] to_axis(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return AXIS_W'(v);
    endfunction

    task automatic pick_point(output logic signed [AXIS_W-1:0] px, py);
        case ($urandom_range(0, 9))
            0: begin
                px = AXIS_W'($urandom);
                py = AXIS_W'($urandom);
            end
            1: begin
                px = to_axis(int'($urandom_range(0, 8)) - 4);
                py = to_axis(int'($urandom_range(0, 8)) - 4);
            end
            default: begin
                px = to_axis(int'($urandom_range(0, 32768)) - 16384);
                py = to_axis(int'($urandom_range(0, 32768)) - 16384);
            end
        endcase
    endtask

    // Places a point close to one of the sector's angle or radius edges.
    task automatic probe_point(output logic signed [AXIS_W-1:0] px, py);
        int  a, r;
        real theta;
        a = ($urandom_range(0, 1) ? cur_angle_lo : cur_angle_hi)
            + int'($urandom_range(0, 80)) - 40;
        case ($urandom_range(0, 2))
            0:       r = cur_radius_lo + int'($urandom_range(0, 6)) - 3;
            1:       r = cur_radius_hi + int'($urandom_range(0, 6)) - 3;
            default: r = $urandom_range(0, 16384);
        endcase
        theta = a * PI / 32768.0;
        px = to_axis($rtoi(r * $cos(theta)));
        py = to_axis($rtoi(r * $sin(theta)));
    endtask

    task automatic random_sample();
        logic signed [AXIS_W-1:0] ax, ay, bx, by;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 3) begin
            ax = '0;
            ay = '0;
        end else if (kind < 35) begin
            probe_point(ax, ay);
        end else begin
            pick_point(ax, ay);
        end
        pick_point(bx, by);
        if (cur_use_left != 0) send_sample(ax, ay, bx, by);
        else send_sample(bx, by, ax, ay);
    endtask

    task automatic random_config();
        int lo, hi;
        write_reg(CFG_USE_LEFT, CFG_DATA_W'($urandom_range(0, 1)));
        case ($urandom_range(0, 4))
            0: begin
                lo = -32768;
                hi = 32768;
            end
            1: begin
                lo = int'($urandom_range(0, 65536)) - 32768;
                hi = lo + int'($urandom_range(0, 32768 - lo));
            end
            2: begin
                hi = int'($urandom_range(0, 32768)) - 32768;
                lo = hi + 1 + int'($urandom_range(0, 32767 - hi));
            end
            3: begin
                lo = $urandom_range(0, 17'h1FFFF);
                hi = $urandom_range(0, 17'h1FFFF);
            end
            default: begin
                lo = 32768;
                hi = $urandom_range(0, 1) ? -32768 : 32768;
            end
        endcase
        write_reg(CFG_ANGLE_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_ANGLE_HIGH, CFG_DATA_W'(hi));
        case ($urandom_range(0, 3))
            0: begin
                lo = 0;
                hi = 32767;
            end
            1: begin
                lo = $urandom_range(0, 16000);
                hi = lo + 1 + int'($urandom_range(0, 16000));
            end
            2: begin
                lo = $urandom_range(0, 17'h1FFFF);
                hi = $urandom_range(0, 17'h1FFFF);
            end
            default: begin
                lo = 32767;
                hi = $urandom_range(0, 32767);
            end
        endcase
        write_reg(CFG_RADIUS_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_RADIUS_HIGH, CFG_DATA_W'(hi));
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    initial begin
        int remaining, burst, gap, phase;
        cycles        = 0;
        requests_sent = 0;
        settings_used = 1;
        cur_use_left  = 0;
        cur_angle_lo  = -32768;
        cur_angle_hi  = 32768;
        cur_radius_lo = 0;
        cur_radius_hi = 32767;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_left_x    = '0;
        i_left_y    = '0;
        i_right_x   = '0;
        i_right_y   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_USE_LEFT;
        i_cfg_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: right stick, full circle, full radius range.
        send_sample(16'sd100, 16'sd100, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sd0);
        send_sample(16'sd0, 16'sd0, -16'sd16384, -16'sd1);
        pause_sender(2);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_sample(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
        send_sample(16'sd0, 16'sd0, -16'sd32768, -16'sd32768);
        send_sample(16'sd0, 16'sd0, 16'sd32767, -16'sd32768);
        pause_sender(1);
        send_sample(16'sd0, 16'sd0, -16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd1, 16'sd0);
        send_sample(-16'sd1, -16'sd1, -16'sd16384, 16'sd16384);
        wait_idle();

        // Left stick, a sector wrapped through the negative x axis, radius in [8192, 12000).
        write_reg(CFG_USE_LEFT, 17'd1);
        write_reg(CFG_ANGLE_LOW, 17'(16384));
        write_reg(CFG_ANGLE_HIGH, 17'(-16384));
        write_reg(CFG_RADIUS_LOW, 17'd8192);
        write_reg(CFG_RADIUS_HIGH, 17'd12000);
        write_reg(CFG_FIRST_UNUSED, 17'h1FFFF);
        settings_used++;
        send_sample(-16'sd8192, 16'sd0, 16'sd0, 16'sd0);
        send_sample(-16'sd8191, 16'sd0, 16'sd0, 16'sd0);
        send_sample(-16'sd12000, 16'sd0, 16'sd0, 16'sd0);
        send_sample(-16'sd11999, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd10000, -16'sd9000, 16'sd0);
        send_sample(16'sd0, -16'sd10000, -16'sd9000, 16'sd0);
        send_sample(-16'sd10000, -16'sd10, 16'sd0, 16'sd0);
        wait_idle();

        // Register extremes: every radius test fails.
        write_reg(CFG_USE_LEFT, 17'd0);
        write_reg(CFG_ANGLE_LOW, 17'(32768));
        write_reg(CFG_ANGLE_HIGH, 17'(-32768));
        write_reg(CFG_RADIUS_LOW, 17'd32767);
        write_reg(CFG_RADIUS_HIGH, 17'd0);
        settings_used++;
        send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_sample(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            random_config();
            remaining = PHASE_REQUESTS;
            while (remaining > 0) begin
                burst = $urandom_range(1, 40);
                if (burst > remaining) burst = remaining;
                repeat (burst) random_sample();
                remaining -= burst;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                pause_sender(gap);
            end
            wait_idle();
        end

        $display("Sent %0d requests across %0d register settings, in bursts and with gaps.",
                 requests_sent, settings_used);
        $display("Checked %0d sector decisions, %0d of them inside the sector.", checked, hits);
        if (errors == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
